@@ sv/idepc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idepc_pkg
// Shared types and constants of the IDE interface paging controller: bus
// command codes, drive strobe codes, low bank sources and the result beat.
// ----------------------------------------------------------------------------
package idepc_pkg;

  localparam int RAM_PAGE_BITS_DEF = 2;
  localparam int HIGH_PAGE_W       = 6;

  localparam logic [7:0]  CTRL_PORT    = 8'hE3;
  localparam logic [7:0]  IDE_PORT     = 8'hA3;
  localparam logic [7:0]  PORT_MASK    = 8'hE3;
  localparam logic [7:0]  REG_BITS     = 8'h1C;
  localparam int          MAPRAM_IDX   = 6;
  localparam int          CONMEM_IDX   = 7;
  localparam logic [12:0] EXIT_TRAP_HI = 13'h03FF;
  localparam logic [7:0]  INSTANT_HI   = 8'h3D;
  localparam logic [15:0] TRAP_RST0    = 16'h0000;
  localparam logic [15:0] TRAP_RST8    = 16'h0008;
  localparam logic [15:0] TRAP_IRQ     = 16'h0038;
  localparam logic [15:0] TRAP_NMI     = 16'h0066;
  localparam logic [15:0] TRAP_LOAD    = 16'h04C6;
  localparam logic [15:0] TRAP_SAVE    = 16'h0562;

  typedef enum logic [1:0] {
    CMD_PORT_RD = 2'd0,
    CMD_PORT_WR = 2'd1,
    CMD_FETCH   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ACC_NONE  = 2'd0,
    ACC_READ  = 2'd1,
    ACC_WRITE = 2'd2
  } acc_t;

  typedef enum logic [1:0] {
    LSRC_HOST_ROM = 2'd0,
    LSRC_IF_ROM   = 2'd1,
    LSRC_RAM3     = 2'd2
  } lsrc_t;

  typedef struct packed {
    logic [7:0]             cpu_read_data;
    logic                   bus_driven;
    acc_t                   ide_access;
    logic                   ide_word_access;
    logic [2:0]             ide_register;
    logic [15:0]            ide_write_value;
    logic                   paged_in;
    lsrc_t                  low_source;
    logic                   low_writable;
    logic [HIGH_PAGE_W-1:0] high_ram_page;
    logic                   high_writable;
    logic                   reread_opcode;
  } result_t;

endpackage

@@ sv/idepc_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idepc_core
// Port decode, data word byte pairing, trap paging and memory map for one
// bus beat. Holds the interface state, which advances on step and on cfg_we.
// ----------------------------------------------------------------------------
module idepc_core #(
  parameter int RAM_PAGE_BITS = idepc_pkg::RAM_PAGE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [1:0]          cmd,
  input  logic [15:0]         addr,
  input  logic [7:0]          data,
  input  logic [15:0]         ide_bus_in,
  input  logic                rear_romcs,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  output idepc_pkg::result_t  res
);
  import idepc_pkg::*;

  logic       jumper_e_r, jumper_e_nxt;
  logic [7:0] ctrl_r, ctrl_nxt, ctrl_step;
  logic       auto_r, auto_nxt, auto_step;
  logic       phase_r, phase_nxt, phase_step;
  logic [7:0] rd_hi_r, rd_hi_nxt, rd_hi_step;
  logic [7:0] wr_lo_r, wr_lo_nxt, wr_lo_step;

  logic                     ide_hit, reg_hit, ctrl_hit, entry_trap;
  logic                     conmem, mapram;
  logic [RAM_PAGE_BITS-1:0] page;

  assign ide_hit  = (addr[7:0] & PORT_MASK) == IDE_PORT;
  assign reg_hit  = |(addr[7:0] & REG_BITS);
  assign ctrl_hit = addr[7:0] == CTRL_PORT;
  assign entry_trap = (addr == TRAP_RST0) || (addr == TRAP_RST8) || (addr == TRAP_IRQ) ||
                      (addr == TRAP_NMI) || (addr == TRAP_LOAD) || (addr == TRAP_SAVE);

  // access decode and state update
  always_comb begin
    ctrl_step  = ctrl_r;
    auto_step  = auto_r;
    phase_step = phase_r;
    rd_hi_step = rd_hi_r;
    wr_lo_step = wr_lo_r;
    res        = '0;
    case (cmd_t'(cmd))
      CMD_PORT_RD: begin
        res.cpu_read_data = data;
        if (ide_hit) begin
          res.bus_driven = 1'b1;
          if (reg_hit) begin
            phase_step        = 1'b0;
            res.cpu_read_data = data & ide_bus_in[7:0];
            res.ide_access    = ACC_READ;
            res.ide_register  = addr[4:2];
          end else begin
            phase_step = ~phase_r;
            if (!phase_r) begin
              rd_hi_step          = ide_bus_in[15:8];
              res.cpu_read_data   = data & ide_bus_in[7:0];
              res.ide_access      = ACC_READ;
              res.ide_word_access = 1'b1;
            end else begin
              res.cpu_read_data = data & rd_hi_r;
            end
          end
        end
      end
      CMD_PORT_WR: begin
        if (ctrl_hit) begin
          phase_step = 1'b0;
          ctrl_step  = data | (ctrl_r & (8'd1 << MAPRAM_IDX));
        end else if (ide_hit) begin
          if (reg_hit) begin
            phase_step          = 1'b0;
            res.ide_access      = ACC_WRITE;
            res.ide_register    = addr[4:2];
            res.ide_write_value = {8'h00, data};
          end else begin
            phase_step = ~phase_r;
            if (!phase_r) begin
              wr_lo_step = data;
            end else begin
              res.ide_access      = ACC_WRITE;
              res.ide_word_access = 1'b1;
              res.ide_write_value = {data, wr_lo_r};
            end
          end
        end
      end
      CMD_FETCH: begin
        if (jumper_e_r) begin
          if (addr[15:3] == EXIT_TRAP_HI) begin
            auto_step = 1'b0;
          end else if (entry_trap) begin
            auto_step = 1'b1;
          end else if (addr[15:8] == INSTANT_HI) begin
            auto_step         = 1'b1;
            res.reread_opcode = 1'b1;
          end
        end
      end
      CMD_NONE: begin
      end
      default: begin
      end
    endcase

    // memory map after the access
    conmem = ctrl_step[CONMEM_IDX];
    mapram = ctrl_step[MAPRAM_IDX];
    page   = ctrl_step[RAM_PAGE_BITS-1:0];
    if ((conmem || auto_step) && !rear_romcs) begin
      res.paged_in      = 1'b1;
      res.high_ram_page = HIGH_PAGE_W'(page);
      res.high_writable = (page != RAM_PAGE_BITS'(3)) || conmem || !mapram;
      if (mapram && !conmem) begin
        res.low_source   = LSRC_RAM3;
        res.low_writable = 1'b0;
      end else if (conmem && !jumper_e_r) begin
        res.low_source   = LSRC_IF_ROM;
        res.low_writable = 1'b1;
      end else begin
        res.low_source   = LSRC_IF_ROM;
        res.low_writable = 1'b0;
      end
    end
  end

  always_comb begin
    ctrl_nxt     = step ? ctrl_step  : ctrl_r;
    phase_nxt    = step ? phase_step : phase_r;
    rd_hi_nxt    = step ? rd_hi_step : rd_hi_r;
    wr_lo_nxt    = step ? wr_lo_step : wr_lo_r;
    auto_nxt     = step ? auto_step  : auto_r;
    jumper_e_nxt = jumper_e_r;
    if (cfg_we) begin
      jumper_e_nxt = cfg_wdata;
      if (cfg_wdata != jumper_e_r) auto_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jumper_e_r <= 1'b1;
      ctrl_r     <= '0;
      auto_r     <= 1'b0;
      phase_r    <= 1'b0;
      rd_hi_r    <= '0;
      wr_lo_r    <= '0;
    end else begin
      jumper_e_r <= jumper_e_nxt;
      ctrl_r     <= ctrl_nxt;
      auto_r     <= auto_nxt;
      phase_r    <= phase_nxt;
      rd_hi_r    <= rd_hi_nxt;
      wr_lo_r    <= wr_lo_nxt;
    end
  end

  // mapram is write-once until reset
  a_mapram_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_r[MAPRAM_IDX] |=> ctrl_r[MAPRAM_IDX])
    else $error("mapram bit cleared without reset");

  a_idle_strobe_fields: assert property (@(posedge clk)
    (res.ide_access == ACC_NONE) |-> (!res.ide_word_access && res.ide_register == 3'd0 &&
                                      res.ide_write_value == 16'h0000))
    else $error("strobe fields set with no drive access");

  a_word_phase_flip: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !cfg_we && cmd == CMD_PORT_RD && ide_hit && !reg_hit && !phase_r)
      |=> phase_r)
    else $error("data read did not advance byte phase");

  a_reread_pages: assert property (@(posedge clk)
    res.reread_opcode |-> (res.paged_in == !rear_romcs))
    else $error("instant page-in without paging");

endmodule

@@ sv/ide_interface_paging_controller_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ide_interface_paging_controller_top
// Bus-side logic of an 8-bit CPU to IDE interface with automatic rom paging.
//
// Input channel (in_valid/in_ready): one beat per CPU bus access, a port
// read, port write or opcode fetch, with the drive's bus value and the rear
// rom disable. Output channel (out_valid/out_ready): one beat per access with
// cpu read data, drive strobe, register select, write value and the memory
// map that holds after the access.
// An accepted beat is registered in the output register, or in the skid
// register while the output stalls. One beat per cycle is taken while the
// skid register is empty. A two-entry output buffer (output register plus
// skid register) keeps in_ready high for one more beat when out_ready
// drops; in_ready falls only while the skid register is occupied.
// cfg_we writes the jumper bit at once; write it only while no beat is in
// flight. Synchronous reset sets the jumper, clears the control byte, auto
// paging, byte phase and latches, and empties both output buffers.
// ----------------------------------------------------------------------------
module ide_interface_paging_controller_top #(
  parameter int RAM_PAGE_BITS = idepc_pkg::RAM_PAGE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic                                cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_cmd,
  input  logic [15:0]                         in_addr,
  input  logic [7:0]                          in_data,
  input  logic [15:0]                         in_ide_bus_in,
  input  logic                                in_rear_romcs,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          out_cpu_read_data,
  output logic                                out_bus_driven,
  output logic [1:0]                          out_ide_access,
  output logic                                out_ide_word_access,
  output logic [2:0]                          out_ide_register,
  output logic [15:0]                         out_ide_write_value,
  output logic                                out_paged_in,
  output logic [1:0]                          out_low_source,
  output logic                                out_low_writable,
  output logic [idepc_pkg::HIGH_PAGE_W-1:0]   out_high_ram_page,
  output logic                                out_high_writable,
  output logic                                out_reread_opcode
);
  import idepc_pkg::*;

  result_t res;
  result_t out_r, out_nxt, skid_r, skid_nxt;
  logic    out_vld_r, out_vld_nxt, skid_vld_r, skid_vld_nxt;
  logic    in_fire, out_fire;

  assign in_ready = !skid_vld_r;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_vld_r && out_ready;

  idepc_core #(
    .RAM_PAGE_BITS (RAM_PAGE_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (in_fire),
    .cmd        (in_cmd),
    .addr       (in_addr),
    .data       (in_data),
    .ide_bus_in (in_ide_bus_in),
    .rear_romcs (in_rear_romcs),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .res        (res)
  );

  // output register with skid stage
  always_comb begin
    out_nxt      = out_r;
    out_vld_nxt  = out_vld_r;
    skid_nxt     = skid_r;
    skid_vld_nxt = skid_vld_r;
    if (in_fire) begin
      if (!out_vld_r || out_ready) begin
        out_nxt     = res;
        out_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = res;
        skid_vld_nxt = 1'b1;
      end
    end else if (out_fire) begin
      if (skid_vld_r) begin
        out_nxt      = skid_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid           = out_vld_r;
  assign out_cpu_read_data   = out_r.cpu_read_data;
  assign out_bus_driven      = out_r.bus_driven;
  assign out_ide_access      = out_r.ide_access;
  assign out_ide_word_access = out_r.ide_word_access;
  assign out_ide_register    = out_r.ide_register;
  assign out_ide_write_value = out_r.ide_write_value;
  assign out_paged_in        = out_r.paged_in;
  assign out_low_source      = out_r.low_source;
  assign out_low_writable    = out_r.low_writable;
  assign out_high_ram_page   = out_r.high_ram_page;
  assign out_high_writable   = out_r.high_writable;
  assign out_reread_opcode   = out_r.reread_opcode;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid beat held with empty output register");

  a_skid_from_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!skid_vld_r && out_vld_r && !out_ready && in_valid) |=> skid_vld_r)
    else $error("stalled beat not caught in skid register");

  a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_vld_r)
    else $error("accepted beat produced no output");

endmodule
